// File: rtl/orsat_pkg.sv
`timescale 1ns / 1ps

package orsat_pkg;

  // Operand and accumulator widths of the shared multiply-accumulate unit
  localparam int COORD_W = 32;                  // Q16.16 coordinates and coefficients
  localparam int FRAC_W  = 16;
  localparam int MUL_A_W = COORD_W + 1;         // edge normal components need one more bit
  localparam int PROD_W  = MUL_A_W + COORD_W;
  localparam int ACC_W   = PROD_W + 1;          // sum of two products

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [MUL_A_W-1:0] opa_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  typedef struct packed {
    logic en;   // update accumulator
    logic clr;  // start from bias instead of accumulator
  } mac_ctl_t;

endpackage

// File: rtl/orsat_mac.sv
`timescale 1ns / 1ps

module orsat_mac import orsat_pkg::*; (
  input  logic     clk,
  input  mac_ctl_t ctl,
  input  opa_t     op_a,
  input  coord_t   op_b,
  input  acc_t     bias,
  output acc_t     acc
);

  logic signed [PROD_W-1:0] prod;
  acc_t                     acc_base;

  assign prod     = op_a * op_b;
  assign acc_base = ctl.clr ? bias : acc;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= acc_base + acc_t'(prod);
    end
  end

endmodule

// File: rtl/oriented_rect_overlap_sat_unit.sv
`timescale 1ns / 1ps
// Oriented rectangle overlap test (separating axis test), Q16.16.
//
// Input channel (in_valid/in_ready): one transfer carries a rectangle's local
// bounds and its 2x3 affine transform. cmd = 0 loads rectangle A and yields no
// result; cmd = 1 brings rectangle B and yields exactly one result transfer on
// the output channel (out_valid/out_ready) with overlap = 1 unless some edge
// normal of A or B separates the two. Touching counts as overlap.
//
// All arithmetic runs on one shared 33x32 multiply-accumulate unit under a
// small sequencer; in_ready is high only while the sequencer is idle.
//   load (cmd 0): each of the 8 corner coords takes two MAC terms and one
//                 store; in_ready returns after the last store
//   test (cmd 1): the same transform, then per axis two fetch steps, the
//                 projection of all 8 corners, one fold and one decide step;
//                 out_valid and in_ready follow; a separating axis ends it early.
// Each projection takes two MAC terms (nx*x, then + ny*y).
// The result sits in an output register: a stalled receiver does not block the
// next transfer in; the next test's result waits in the decide step until free.
// Reset (rst, synchronous) idles the sequencer and drops out_valid. A's stored
// corners are not cleared; a test before the first load gives no defined answer.

module oriented_rect_overlap_sat_unit import orsat_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic   cmd,
  input  coord_t rect_left,
  input  coord_t rect_top,
  input  coord_t rect_width,
  input  coord_t rect_height,
  input  coord_t m_xx,
  input  coord_t m_xy,
  input  coord_t m_tx,
  input  coord_t m_yx,
  input  coord_t m_yy,
  input  coord_t m_ty,
  output logic   out_valid,
  input  logic   out_ready,
  output logic   overlap
);

  localparam logic [3:0] ST_IDLE = 4'd0;  // waiting for a transfer
  localparam logic [3:0] ST_XF   = 4'd1;  // corner transform, two MAC terms
  localparam logic [3:0] ST_XW   = 4'd2;  // round, saturate, store corner coord
  localparam logic [3:0] ST_NA   = 4'd3;  // fetch first corner of edge
  localparam logic [3:0] ST_NB   = 4'd4;  // fetch second corner, form normal
  localparam logic [3:0] ST_PM   = 4'd5;  // project 8 corners, two MAC terms each
  localparam logic [3:0] ST_PT   = 4'd6;  // fold last projection into min/max
  localparam logic [3:0] ST_DEC  = 4'd7;  // interval check on this axis

  localparam coord_t COORD_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN  = {1'b1, {(COORD_W-1){1'b0}}};
  localparam acc_t   ROUND_HALF = acc_t'(1) <<< (FRAC_W - 1);
  localparam int     RND_W      = ACC_W - FRAC_W;

  function automatic coord_t sat_sum(input logic signed [COORD_W:0] s);
    if (s[COORD_W] != s[COORD_W-1]) begin
      return s[COORD_W] ? COORD_MIN : COORD_MAX;
    end
    return s[COORD_W-1:0];
  endfunction

  // Q34.32 accumulator -> Q16.16 (rounding bias already added), saturated
  function automatic coord_t sat_round(input acc_t a);
    logic signed [RND_W-1:0] q;
    q = a[ACC_W-1:FRAC_W];
    if ((&q[RND_W-1:COORD_W-1]) || !(|q[RND_W-1:COORD_W-1])) begin
      return q[COORD_W-1:0];
    end
    return q[RND_W-1] ? COORD_MIN : COORD_MAX;
  endfunction

  logic [3:0] state;

  // latched item
  logic   cmd_r;
  coord_t lft, top_r, rgt, bot;
  coord_t mxx, mxy, mtx, myx, myy, mty;

  // corner store: entries 0..3 rectangle A, 4..7 rectangle B
  coord_t cx [8];
  coord_t cy [8];
  logic [2:0] rd_addr;
  coord_t     rd_x, rd_y;

  // sequencer counters
  logic [2:0] xf_idx;   // {corner, coord}
  logic       term;     // which MAC term
  logic [2:0] axis;     // {rect, edge}
  logic [2:0] pt;       // corner being projected

  // axis and projection bookkeeping
  coord_t ti_x, ti_y;
  opa_t   nx, ny;
  logic   pend, pend_set, pend_first;
  acc_t   min_a, max_a, min_b, max_b;
  logic   sep;
  logic   res_load;     // final decision goes into the output register

  // shared unit
  mac_ctl_t ctl;
  opa_t     op_a;
  coord_t   op_b;
  acc_t     bias;
  acc_t     acc;

  // transform operands for the current corner coordinate
  logic [1:0] xf_corner;
  coord_t     loc_x, loc_y, xf_c0, xf_c1, xf_t;

  assign in_ready  = (state == ST_IDLE);
  assign xf_corner = xf_idx[2:1];
  // corners: (l,t) (r,t) (r,b) (l,b)
  assign loc_x     = (xf_corner[0] ^ xf_corner[1]) ? rgt : lft;
  assign loc_y     = xf_corner[1] ? bot : top_r;
  assign xf_c0     = xf_idx[0] ? myx : mxx;
  assign xf_c1     = xf_idx[0] ? myy : mxy;
  assign xf_t      = xf_idx[0] ? mty : mtx;

  assign rd_x = cx[rd_addr];
  assign rd_y = cy[rd_addr];

  assign sep = (max_a < min_b) || (max_b < min_a);

  // hold until the output register is free
  assign res_load = (state == ST_DEC) && (sep || axis == 3'd7) &&
                    (!out_valid || out_ready);

  always_comb begin
    case (state)
      ST_NA:   rd_addr = axis;
      ST_NB:   rd_addr = {axis[2], axis[1:0] + 2'd1};
      default: rd_addr = pt;
    endcase
  end

  always_comb begin
    ctl  = '0;
    op_a = '0;
    op_b = '0;
    bias = '0;
    case (state)
      ST_XF: begin
        ctl.en  = 1'b1;
        ctl.clr = !term;
        op_a    = term ? opa_t'(xf_c1) : opa_t'(xf_c0);
        op_b    = term ? loc_y : loc_x;
        bias    = (acc_t'(xf_t) <<< FRAC_W) + ROUND_HALF;
      end
      ST_PM: begin
        ctl.en  = 1'b1;
        ctl.clr = !term;
        op_a    = term ? ny : nx;
        op_b    = term ? rd_y : rd_x;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  orsat_mac u_mac (
    .clk  (clk),
    .ctl  (ctl),
    .op_a (op_a),
    .op_b (op_b),
    .bias (bias),
    .acc  (acc)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      xf_idx    <= '0;
      term      <= 1'b0;
      axis      <= '0;
      pt        <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= (state == ST_PM) && term;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state  <= ST_XF;
            xf_idx <= '0;
            term   <= 1'b0;
          end
        end
        ST_XF: begin
          term <= ~term;
          if (term) begin
            state <= ST_XW;
          end
        end
        ST_XW: begin
          if (xf_idx == 3'd7) begin
            axis  <= '0;
            state <= cmd_r ? ST_NA : ST_IDLE;
          end else begin
            xf_idx <= xf_idx + 3'd1;
            state  <= ST_XF;
          end
        end
        ST_NA: begin
          state <= ST_NB;
        end
        ST_NB: begin
          pt    <= '0;
          term  <= 1'b0;
          state <= ST_PM;
        end
        ST_PM: begin
          term <= ~term;
          if (term) begin
            pt <= pt + 3'd1;
            if (pt == 3'd7) begin
              state <= ST_PT;
            end
          end
        end
        ST_PT: begin
          state <= ST_DEC;
        end
        ST_DEC: begin
          if (res_load) begin
            state <= ST_IDLE;
          end else if (!sep && axis != 3'd7) begin
            axis  <= axis + 3'd1;
            state <= ST_NA;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      cmd_r <= cmd;
      lft   <= rect_left;
      top_r <= rect_top;
      rgt   <= sat_sum((COORD_W+1)'(rect_left) + (COORD_W+1)'(rect_width));
      bot   <= sat_sum((COORD_W+1)'(rect_top) + (COORD_W+1)'(rect_height));
      mxx   <= m_xx;
      mxy   <= m_xy;
      mtx   <= m_tx;
      myx   <= m_yx;
      myy   <= m_yy;
      mty   <= m_ty;
    end
    if (state == ST_XW) begin
      if (xf_idx[0]) begin
        cy[{cmd_r, xf_corner}] <= sat_round(acc);
      end else begin
        cx[{cmd_r, xf_corner}] <= sat_round(acc);
      end
    end
    if (state == ST_NA) begin
      ti_x <= rd_x;
      ti_y <= rd_y;
    end
    if (state == ST_NB) begin
      // normal of edge i->j: (-(yj - yi), xj - xi)
      nx <= opa_t'(ti_y) - opa_t'(rd_y);
      ny <= opa_t'(rd_x) - opa_t'(ti_x);
    end
    if (state == ST_PM && term) begin
      pend_set   <= pt[2];
      pend_first <= (pt[1:0] == 2'd0);
    end
    if (res_load) begin
      overlap <= !sep;
    end
    // fold finished projection, overlaps the next corner's first MAC term
    if (pend) begin
      if (pend_set) begin
        if (pend_first || acc < min_b) min_b <= acc;
        if (pend_first || acc > max_b) max_b <= acc;
      end else begin
        if (pend_first || acc < min_a) min_a <= acc;
        if (pend_first || acc > max_a) max_a <= acc;
      end
    end
  end

  // every projection is folded in before the axis is judged
  a_no_pend_at_dec: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DEC) |-> !pend)
    else $error("projection still pending at axis decision");

  // a result only appears out of the decision step
  a_result_from_dec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DEC))
    else $error("result raised outside decision");

  // normal is formed right after fetching the edge's first corner
  a_nb_after_na: assert property (@(posedge clk) disable iff (rst)
    (state == ST_NB) |-> $past(state == ST_NA))
    else $error("normal formed without first corner");

  // a corner coordinate is stored only after both transform terms
  a_xw_after_terms: assert property (@(posedge clk) disable iff (rst)
    (state == ST_XW) |-> ($past(state == ST_XF) && $past(term)))
    else $error("corner stored before both MAC terms");

  // an accepted transfer starts the corner transform
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_XF))
    else $error("transfer did not start the transform");

endmodule

// File: test/tb_oriented_rect_overlap_sat_unit.sv
`timescale 1ns / 1ps

module tb_oriented_rect_overlap_sat_unit import orsat_pkg::*;;

  // cmd codes
  localparam logic CMD_LOAD_A = 1'b0;  // store rectangle A, no result
  localparam logic CMD_TEST_B = 1'b1;  // bring rectangle B, one result

  // handy Q16.16 values
  localparam coord_t ONE    = 32'sh0001_0000;
  localparam coord_t HALF   = 32'sh0000_8000;
  localparam coord_t R45    = 32'sd46341;         // cos 45 deg
  localparam coord_t C_MAX  = 32'sh7FFF_FFFF;
  localparam coord_t C_MIN  = 32'sh8000_0000;

  localparam int ITEM_GOAL  = 550;
  localparam int DRAIN_CYC  = 200;                // covers a full 8-axis test

  // Wide enough for every exact intermediate: 33b normal x 32b coord, summed.
  typedef logic signed [79:0] wide_t;

  localparam wide_t W_MAX = 80'sd2147483647;
  localparam wide_t W_MIN = -80'sd2147483648;

  typedef struct {
    logic   cmd;
    coord_t left, top, width, height;
    coord_t xx, xy, tx, yx, yy, ty;
  } rect_item_t;

  // Tracks A's corners and queues the overlap answer of every test.
  class overlap_scoreboard;
    coord_t a_x[4], a_y[4];
    bit     overlap_q[$];
    int     errors, loads, tests, separated;

    function coord_t clamp32(wide_t v);
      if (v > W_MAX) return C_MAX;
      if (v < W_MIN) return C_MIN;
      return coord_t'(v);
    endfunction

    // exact c0*x + c1*y + t, rounded half up to Q16.16, then saturated
    function coord_t transform_coord(coord_t c0, coord_t c1, coord_t t,
                                     coord_t x, coord_t y);
      wide_t k0, k1, kt, vx, vy, acc;
      k0 = c0; k1 = c1; kt = t; vx = x; vy = y;
      acc = k0 * vx + k1 * vy + (kt <<< 16) + 80'sd32768;
      return clamp32(acc >>> 16);
    endfunction

    function void rect_corners(rect_item_t it, output coord_t cx[4],
                               output coord_t cy[4]);
      wide_t  bl, bt, bw, bh;
      coord_t r, b;
      coord_t lx[4], ly[4];
      bl = it.left; bt = it.top; bw = it.width; bh = it.height;
      r = clamp32(bl + bw);
      b = clamp32(bt + bh);
      lx = '{it.left, r, r, it.left};
      ly = '{it.top, it.top, b, b};
      for (int i = 0; i < 4; i++) begin
        cx[i] = transform_coord(it.xx, it.xy, it.tx, lx[i], ly[i]);
        cy[i] = transform_coord(it.yx, it.yy, it.ty, lx[i], ly[i]);
      end
    endfunction

    function wide_t project(wide_t nx, wide_t ny, coord_t x, coord_t y);
      wide_t vx, vy;
      vx = x; vy = y;
      return nx * vx + ny * vy;
    endfunction

    // Edge normals of A then B; a strict gap on any axis means separated.
    function bit sat_overlap(coord_t bx[4], coord_t by[4]);
      coord_t px[4], py[4];
      wide_t  nx, ny, p0, p1, pa, pb, mina, maxa, minb, maxb;
      int     j;
      for (int k = 0; k < 8; k++) begin
        if (k < 4) begin
          px = a_x; py = a_y;
        end else begin
          px = bx; py = by;
        end
        j  = (k + 1) % 4;
        p0 = py[j]; p1 = py[k % 4];
        nx = p1 - p0;
        p0 = px[j]; p1 = px[k % 4];
        ny = p0 - p1;
        for (int c = 0; c < 4; c++) begin
          pa = project(nx, ny, a_x[c], a_y[c]);
          pb = project(nx, ny, bx[c], by[c]);
          if (c == 0 || pa < mina) mina = pa;
          if (c == 0 || pa > maxa) maxa = pa;
          if (c == 0 || pb < minb) minb = pb;
          if (c == 0 || pb > maxb) maxb = pb;
        end
        if (maxa < minb || maxb < mina) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_rect(rect_item_t it);
      coord_t bx[4], by[4];
      bit     ov;
      if (it.cmd == CMD_LOAD_A) begin
        rect_corners(it, a_x, a_y);
        loads++;
      end else begin
        rect_corners(it, bx, by);
        ov = sat_overlap(bx, by);
        overlap_q = {overlap_q, ov};
        tests++;
        if (!ov) separated++;
      end
    endfunction

    function void check_overlap(bit got);
      bit want;
      if (overlap_q.size() == 0) begin
        $display("%0t ns: overlap %0b with no test outstanding", $time, got);
        errors++;
        return;
      end
      want = overlap_q.pop_front();
      if (got !== want) begin
        $display("%0t ns: overlap expected %0b, got %0b", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  logic   cmd = CMD_LOAD_A;
  coord_t rect_left = '0, rect_top = '0, rect_width = '0, rect_height = '0;
  coord_t m_xx = '0, m_xy = '0, m_tx = '0, m_yx = '0, m_yy = '0, m_ty = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  logic   overlap;

  overlap_scoreboard sb = new;
  bit steady = 1'b0;   // no idling on either side while set
  int sent = 0;
  int rdy_left = 0;
  rect_item_t directed_q[$];

  oriented_rect_overlap_sat_unit u_dut (
    .clk, .rst, .in_valid, .in_ready, .cmd,
    .rect_left, .rect_top, .rect_width, .rect_height,
    .m_xx, .m_xy, .m_tx, .m_yx, .m_yy, .m_ty,
    .out_valid, .out_ready, .overlap
  );

  always #2 clk = ~clk;

  // Gap / stall length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Receiver: alternates ready and stall stretches of random length.
  always @(posedge clk) begin
    if (steady) begin
      out_ready <= 1'b1;
    end else if (rdy_left == 0) begin
      out_ready <= ~out_ready;
      rdy_left = out_ready ? pick_gap() : $urandom_range(0, 15);
    end else begin
      rdy_left--;
    end
  end

  // Monitor: both channels sampled with their pre-edge values.
  always @(posedge clk) begin
    rect_item_t seen;
    if (!rst) begin
      if (in_valid && in_ready) begin
        seen.cmd    = cmd;
        seen.left   = rect_left;
        seen.top    = rect_top;
        seen.width  = rect_width;
        seen.height = rect_height;
        seen.xx     = m_xx;
        seen.xy     = m_xy;
        seen.tx     = m_tx;
        seen.yx     = m_yx;
        seen.yy     = m_yy;
        seen.ty     = m_ty;
        sb.note_rect(seen);
      end
      if (out_valid && out_ready) sb.check_overlap(overlap);
    end
  end

  function automatic rect_item_t mk(logic c, coord_t l, coord_t t, coord_t w,
                                    coord_t h, coord_t xx, coord_t xy, coord_t tx,
                                    coord_t yx, coord_t yy, coord_t ty);
    rect_item_t it;
    it.cmd = c; it.left = l; it.top = t; it.width = w; it.height = h;
    it.xx = xx; it.xy = xy; it.tx = tx; it.yx = yx; it.yy = yy; it.ty = ty;
    return it;
  endfunction

  // axis-aligned rectangle, identity transform
  function automatic rect_item_t idr(logic c, coord_t l, coord_t t, coord_t w,
                                     coord_t h);
    return mk(c, l, t, w, h, ONE, 0, 0, 0, ONE, 0);
  endfunction

  function automatic rect_item_t fill(logic c, coord_t v);
    return mk(c, v, v, v, v, v, v, v, v, v, v);
  endfunction

  // append one item to the directed list
  function automatic void add_directed(rect_item_t it);
    directed_q = {directed_q, it};
  endfunction

  function automatic coord_t span(int unsigned r);
    return coord_t'(int'($urandom_range(0, 2 * r)) - int'(r));
  endfunction

  function automatic coord_t size_val();
    coord_t s;
    s = coord_t'($urandom_range(0, 6 * 65536));
    if ($urandom_range(0, 9) == 0) s = -s;
    return s;
  endfunction

  // Plausible geometry: small boxes, scale/shear up to 1.5, nearby offsets.
  function automatic rect_item_t geo_rect(logic c);
    return mk(c, span(8 * 65536), span(8 * 65536), size_val(), size_val(),
              span(98304), span(98304), span(6 * 65536),
              span(98304), span(98304), span(6 * 65536));
  endfunction

  function automatic coord_t wild_val();
    case ($urandom_range(0, 5))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return '0;
      3:       return ONE;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic rect_item_t wild_rect(logic c);
    return mk(c, wild_val(), wild_val(), wild_val(), wild_val(), wild_val(),
              wild_val(), wild_val(), wild_val(), wild_val(), wild_val());
  endfunction

  // Present one item after a random gap and hold it until the transfer.
  task automatic send_rect(input rect_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= it.cmd;
    rect_left   <= it.left;
    rect_top    <= it.top;
    rect_width  <= it.width;
    rect_height <= it.height;
    m_xx        <= it.xx;
    m_xy        <= it.xy;
    m_tx        <= it.tx;
    m_yx        <= it.yx;
    m_yy        <= it.yy;
    m_ty        <= it.ty;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Sender holds off until every queued answer has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.overlap_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int r, n;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // basic cases against a 4x4 box at the origin
    add_directed(idr(CMD_LOAD_A, 0, 0, 4 * ONE, 4 * ONE));
    add_directed(idr(CMD_TEST_B, 2 * ONE, 2 * ONE, 4 * ONE, 4 * ONE));
    add_directed(idr(CMD_TEST_B, 10 * ONE, 0, 2 * ONE, 2 * ONE));
    add_directed(idr(CMD_TEST_B, 4 * ONE, 0, 2 * ONE, 2 * ONE)); // touching
    // diamond whose bounding box touches A's corner but a diagonal separates
    add_directed(mk(CMD_TEST_B, -69512, -69512, 139024, 139024,
                    R45, -R45, 360448, R45, R45, 360448));
    add_directed(idr(CMD_TEST_B, ONE, ONE, 0, 0));               // point B
    // back-to-back loads, then a zero-width A (degenerate edges)
    add_directed(idr(CMD_LOAD_A, 100 * ONE, 0, ONE, ONE));
    add_directed(idr(CMD_LOAD_A, 0, 0, 0, 4 * ONE));
    add_directed(idr(CMD_TEST_B, ONE, 0, 2 * ONE, 2 * ONE));
    add_directed(idr(CMD_TEST_B, -ONE, ONE, 2 * ONE, ONE));
    add_directed(idr(CMD_TEST_B, 3 * ONE, 3 * ONE, -4 * ONE, -4 * ONE));
    // half-LSB ties round up: x scale +0.5 and -0.5 on raw +-1
    add_directed(mk(CMD_LOAD_A, -1, 0, 2, 4, HALF, 0, 0, 0, ONE, 0));
    add_directed(idr(CMD_TEST_B, 1, 2, 0, 0));
    add_directed(idr(CMD_TEST_B, 2, 2, 0, 0));
    add_directed(mk(CMD_LOAD_A, -1, 0, 2, 4, -HALF, 0, 0, 0, ONE, 0));
    add_directed(idr(CMD_TEST_B, -1, 2, 0, 0));
    add_directed(idr(CMD_TEST_B, 0, 2, 0, 0));
    // saturating bound sums and corners, field extremes
    add_directed(mk(CMD_LOAD_A, C_MAX, C_MIN, C_MAX, C_MIN,
                    ONE, 0, 0, 0, ONE, 0));
    add_directed(mk(CMD_TEST_B, C_MIN, C_MAX, C_MAX, C_MIN,
                    C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN));
    add_directed(fill(CMD_TEST_B, C_MAX));
    add_directed(fill(CMD_LOAD_A, C_MIN));
    add_directed(fill(CMD_TEST_B, C_MIN));
    add_directed(fill(CMD_TEST_B, '0));
    foreach (directed_q[i]) send_rect(directed_q[i]);
    wait_drained();

    // Mostly a load followed by a few tests; some lone tests, some noise.
    while (sent < ITEM_GOAL) begin
      steady = (sent >= 250 && sent < 320);
      if ($urandom_range(0, 99) < 5) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 72) begin
        send_rect(geo_rect(CMD_LOAD_A));
        n = $urandom_range(1, 4);
        repeat (n) begin
          if ($urandom_range(0, 6) == 0) send_rect(wild_rect(CMD_TEST_B));
          else send_rect(geo_rect(CMD_TEST_B));
        end
      end else if (r < 88) begin
        send_rect(geo_rect(CMD_TEST_B));
      end else begin
        send_rect(wild_rect(logic'($urandom_range(0, 1))));
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk);
    $display("%0d transfers in: %0d loads of A, %0d tests of B", sent, sb.loads,
             sb.tests);
    $display("%0d tests found a separating axis, %0d found overlap", sb.separated,
             sb.tests - sb.separated);
    if (sb.errors == 0 && sb.overlap_q.size() == 0) begin
      $display("oriented_rect_overlap_sat_unit: match");
    end else begin
      $display("oriented_rect_overlap_sat_unit: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("watchdog expired with %0d results outstanding", sb.overlap_q.size());
    $display("oriented_rect_overlap_sat_unit: mismatch");
    $finish;
  end

endmodule
